// ===== rtl/core/slcfl_pkg.sv =====
package slcfl_pkg;

    // Byte store size and the widths that follow from it.
    localparam int BUF_BYTES = 65536;
    localparam int ADDR_W    = $clog2(BUF_BYTES);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int LEN_W     = 16;
    localparam int SUM_W     = 16;
    localparam int MATCH_W   = 17;

    localparam logic [7:0]         SYNC_BYTE = 8'h7F;
    localparam logic [MATCH_W-1:0] MATCH_SAT = {MATCH_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_FOUND = 2'd0,
        STAT_NONE  = 2'd1,
        STAT_LIMIT = 2'd2
    } stat_t;

    typedef struct packed {
        logic go;
        logic clear;
    } scan_req_t;

    typedef struct packed {
        logic              done;
        logic              found;
        logic [ADDR_W-1:0] offset;
        logic [LEN_W-1:0]  length;
    } scan_rsp_t;

endpackage

// ===== rtl/core/slcfl_ram.sv =====
module slcfl_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/slcfl_scan.sv =====
module slcfl_scan
    import slcfl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  scan_req_t         req,
    input  logic [CNT_W-1:0]  byte_count,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [7:0]        rd_data,
    output scan_rsp_t         rsp
);

    // Read data is registered in the RAM and arrives in the cycle after its address, so each state checks
    // the byte that the state before it asked for.
    typedef enum logic [8:0] {
        S_IDLE = 9'b0_0000_0001,
        S_CAND = 9'b0_0000_0010,
        S_B0   = 9'b0_0000_0100,
        S_B1   = 9'b0_0000_1000,
        S_B2   = 9'b0_0001_0000,
        S_B3   = 9'b0_0010_0000,
        S_SUM  = 9'b0_0100_0000,
        S_W0   = 9'b0_1000_0000,
        S_W1   = 9'b1_0000_0000
    } scan_state_t;

    scan_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cursor_reg, cursor_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [7:0]        lo_reg, lo_next;
    logic              pend_reg, pend_next;

    logic [CNT_W:0]    pos_end4;
    logic [CNT_W:0]    frame_end;
    logic [LEN_W-1:0]  len_rd;

    assign len_rd    = {rd_data, lo_reg};
    assign pos_end4  = {1'b0, pos_reg} + (CNT_W+1)'(4);
    assign frame_end = {1'b0, pos_reg} + (CNT_W+1)'(len_rd) + (CNT_W+1)'(2);

    always_comb
    begin
        state_next  = state_reg;
        cursor_next = cursor_reg;
        pos_next    = pos_reg;
        ptr_next    = ptr_reg;
        rem_next    = rem_reg;
        len_next    = len_reg;
        sum_next    = sum_reg;
        lo_next     = lo_reg;
        pend_next   = pend_reg;
        rd_addr     = pos_reg[ADDR_W-1:0];
        rsp         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.clear)
                begin
                    cursor_next = '0;
                end
                if (req.go)
                begin
                    pos_next   = cursor_reg;
                    state_next = S_CAND;
                end
            end
            S_CAND:
            begin
                // If four bytes no longer fit, no later offset can hold a frame.
                if (pos_end4 > {1'b0, byte_count})
                begin
                    rsp.done   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_B0;
                end
            end
            S_B0:
            begin
                rd_addr = ADDR_W'(pos_reg + CNT_W'(1));
                if (rd_data != SYNC_BYTE)
                begin
                    pos_next   = pos_reg + CNT_W'(1);
                    state_next = S_CAND;
                end
                else
                begin
                    state_next = S_B1;
                end
            end
            S_B1:
            begin
                rd_addr = ADDR_W'(pos_reg + CNT_W'(2));
                if (rd_data != SYNC_BYTE)
                begin
                    pos_next   = pos_reg + CNT_W'(1);
                    state_next = S_CAND;
                end
                else
                begin
                    state_next = S_B2;
                end
            end
            S_B2:
            begin
                rd_addr    = ADDR_W'(pos_reg + CNT_W'(3));
                lo_next    = rd_data;
                state_next = S_B3;
            end
            S_B3:
            begin
                if (frame_end > {1'b0, byte_count})
                begin
                    pos_next   = pos_reg + CNT_W'(1);
                    state_next = S_CAND;
                end
                else
                begin
                    len_next   = len_rd;
                    rem_next   = len_rd;
                    ptr_next   = pos_reg;
                    sum_next   = '0;
                    pend_next  = 1'b0;
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                // One byte read and one byte added per cycle.
                rd_addr  = ptr_reg[ADDR_W-1:0];
                ptr_next = ptr_reg + CNT_W'(1);
                if (pend_reg)
                begin
                    sum_next = sum_reg + SUM_W'(rd_data);
                end
                if (rem_reg != '0)
                begin
                    rem_next  = rem_reg - LEN_W'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_W0;
                end
            end
            S_W0:
            begin
                rd_addr    = ptr_reg[ADDR_W-1:0];
                lo_next    = rd_data;
                state_next = S_W1;
            end
            S_W1:
            begin
                if ({rd_data, lo_reg} == sum_reg)
                begin
                    rsp.done    = 1'b1;
                    rsp.found   = 1'b1;
                    rsp.offset  = pos_reg[ADDR_W-1:0];
                    rsp.length  = len_reg;
                    cursor_next = pos_reg + CNT_W'(1);
                    state_next  = S_IDLE;
                end
                else
                begin
                    pos_next   = pos_reg + CNT_W'(1);
                    state_next = S_CAND;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cursor_reg <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        ptr_reg <= ptr_next;
        rem_reg <= rem_next;
        len_reg <= len_next;
        sum_reg <= sum_next;
        lo_reg  <= lo_next;
    end

endmodule

// ===== rtl/core/sync_length_checksum_frame_locator_unit.sv =====
// Channel   Handshake                    Payload
// command   start (taken when !busy)     command, data_byte
// result    done (one cycle, no stall)   status, frame_offset, frame_length, overflow
// config    cfg_valid / cfg_ready        cfg_data (max_matches)
//
// An append leaves busy low, so appends may come every cycle.
// A clear also leaves busy low. A find that has hit the match limit answers in the cycle after it is taken.
// Any other find walks the byte store through its single read port: an offset is
// rejected at a sync byte, the length bound or the checksum, and a fully checked offset
// sums L bytes for length L; the result is then registered and busy drops with it.
// Reset is asynchronous and active low; the byte store is not cleared, since only
// loaded bytes are ever read. The result receiver cannot stall the block.
module sync_length_checksum_frame_locator_unit
    import slcfl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [1:0]   command,
    input  logic [7:0]   data_byte,
    output logic         done,
    output logic [1:0]   status,
    output logic [15:0]  frame_offset,
    output logic [15:0]  frame_length,
    output logic         overflow,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [16:0]  cfg_data
);

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               dropped_reg, dropped_next;
    logic [MATCH_W-1:0] max_reg;
    logic [MATCH_W-1:0] match_reg, match_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    stat_t              status_reg, status_next;
    logic [15:0]        offset_reg, offset_next;
    logic [15:0]        length_reg, length_next;
    logic               overflow_reg, overflow_next;

    logic               accept;
    logic               full;
    logic               limited;
    logic               wr_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [7:0]         rd_data;
    scan_req_t          req;
    scan_rsp_t          rsp;

    assign accept  = start && !busy_reg;
    assign full    = (count_reg == CNT_W'(BUF_BYTES));
    assign limited = (max_reg != '0) && (match_reg >= max_reg);

    always_comb
    begin
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        match_next    = match_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        offset_next   = offset_reg;
        length_next   = length_reg;
        overflow_next = overflow_reg;
        wr_en         = 1'b0;
        req           = '0;

        if (accept)
        begin
            case (cmd_t'(command))
                CMD_APPEND:
                begin
                    if (!full)
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
                CMD_FIND:
                begin
                    if (limited)
                    begin
                        done_next     = 1'b1;
                        status_next   = STAT_LIMIT;
                        offset_next   = '0;
                        length_next   = '0;
                        overflow_next = dropped_reg;
                    end
                    else
                    begin
                        req.go    = 1'b1;
                        busy_next = 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    count_next   = '0;
                    match_next   = '0;
                    dropped_next = 1'b0;
                    req.clear    = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // The scan ends: register the result beat and free the command side.
        if (rsp.done)
        begin
            busy_next     = 1'b0;
            done_next     = 1'b1;
            overflow_next = dropped_reg;
            if (rsp.found)
            begin
                status_next = STAT_FOUND;
                offset_next = 16'(rsp.offset);
                length_next = rsp.length;
                if (match_reg != MATCH_SAT)
                begin
                    match_next = match_reg + MATCH_W'(1);
                end
            end
            else
            begin
                status_next = STAT_NONE;
                offset_next = '0;
                length_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            max_reg     <= '0;
            match_reg   <= '0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            match_reg   <= match_next;
            busy_reg    <= busy_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                max_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        offset_reg   <= offset_next;
        length_reg   <= length_next;
        overflow_reg <= overflow_next;
    end

    slcfl_ram #(
        .DEPTH (BUF_BYTES),
        .WIDTH (8)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (data_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    slcfl_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .byte_count (count_reg),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .rsp        (rsp)
    );

    assign busy         = busy_reg;
    assign cfg_ready    = 1'b1;
    assign done         = done_reg;
    assign status       = status_reg;
    assign frame_offset = offset_reg;
    assign frame_length = length_reg;
    assign overflow     = overflow_reg;

    // A result without a frame carries zero offset and length.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != STAT_FOUND) |-> (frame_offset == '0) && (frame_length == '0))
        else $error("result without frame has nonzero offset or length");

    // The scanner only finishes a search that was launched.
    a_scan_owned: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> busy_reg)
        else $error("scan finished while no search was pending");

    // The store is never written while a search is reading it.
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !wr_en)
        else $error("store written during a search");

    // A found frame always leaves a nonzero match count behind.
    a_match_counted: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done && rsp.found |=> (match_reg != '0))
        else $error("found frame not counted");

endmodule
